[src/otfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otfr_pkg
// Types, codes and sizes shared by the edge-timed frame receiver.
// ----------------------------------------------------------------------------
package otfr_pkg;

  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned CNT_BITS   = $clog2(FRAME_BITS + 1);
  localparam int unsigned TYPE_LSB   = FRAME_BITS - 4;

  localparam logic [15:0] BIT_WINDOW_RST = 16'd750;
  localparam logic [23:0] TIMEOUT_RST    = 24'd1000000;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef enum logic [1:0] {
    CMD_EDGE = 2'd0,
    CMD_POLL = 2'd1,
    CMD_ARM  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_SLAVE_MODE = 2'd0,
    CFG_BIT_WINDOW = 2'd1,
    CFG_TIMEOUT    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_READY = 3'd0,
    PH_WAIT  = 3'd1,
    PH_START = 3'd2,
    PH_RECV  = 3'd3,
    PH_DONE  = 3'd4,
    PH_BAD   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_OK      = 2'd1,
    ST_BAD     = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef struct packed {
    logic        slave_mode;
    logic [15:0] bit_window;
    logic [23:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] time_us;
    logic        level;
  } item_t;

  typedef struct packed {
    phase_e  phase;
    frame_t  frame;
    cnt_t    cnt;
    time_t   mark;
    status_e status;
  } rx_state_t;

  typedef struct packed {
    logic        ready_res;
    logic        accepted;
    logic        done_res;
    logic [31:0] frame;
    logic [1:0]  status;
  } result_t;

endpackage
`default_nettype wire

[src/opentherm_frame_receiver.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// opentherm_frame_receiver
// Edge-timed receiver for Manchester-coded 32-bit frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one beat per event. tuser carries the command (line edge,
//   poll, arm); tdata carries the microsecond timestamp and the line level.
//   Output stream: exactly one beat per input beat, carrying ready, arm
//   accepted, transaction done, the frame shifted in so far and the status.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   while no beat is in flight. The user must keep to this rule; the block
//   itself does not enforce it. Each beat passes through the input register,
//   then the state update into the result register; a stalled output holds
//   it in the input register.
//   Throughput: one beat per cycle while the output is not stalled; the state
//   update is a single combinational compare, subtract and shift step.
//   Reset clears both stages, puts the receiver in ready with frame and status
//   cleared, and restores the default window and timeout.
//   When the output is stalled one further beat is taken into the input
//   register; after that tready drops until the result beat is taken.
// ----------------------------------------------------------------------------
module opentherm_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // time_us[31:0], line_level, zero pad
  input  wire logic [1:0]  s_axis_tuser_i,  // cmd
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o   // ready_res, accepted, done_res,
                                            // frame[31:0], status[1:0], zero pad
);

  otfr_pkg::cfg_t      cfg_q;
  otfr_pkg::item_t     item_q;
  logic                in_valid_q;
  otfr_pkg::rx_state_t st_q;
  otfr_pkg::rx_state_t st_d;
  otfr_pkg::result_t   res_d;
  otfr_pkg::result_t   res_q;
  logic                out_valid_q;
  logic                advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  otfr_step u_step (
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .cur_i  (st_q),
    .nxt_o  (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_mode <= 1'b0;
      cfg_q.bit_window <= otfr_pkg::BIT_WINDOW_RST;
      cfg_q.timeout    <= otfr_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (otfr_pkg::cfg_idx_e'(cfg_idx_i))
        otfr_pkg::CFG_SLAVE_MODE: cfg_q.slave_mode <= cfg_data_i[0];
        otfr_pkg::CFG_BIT_WINDOW: cfg_q.bit_window <= cfg_data_i[15:0];
        otfr_pkg::CFG_TIMEOUT:    cfg_q.timeout    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.cmd     <= s_axis_tuser_i;
      item_q.time_us <= s_axis_tdata_i[31:0];
      item_q.level   <= s_axis_tdata_i[32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase  <= otfr_pkg::PH_READY;
      st_q.frame  <= '0;
      st_q.cnt    <= '0;
      st_q.mark   <= '0;
      st_q.status <= otfr_pkg::ST_NONE;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, res_q.status, res_q.frame,
                            res_q.done_res, res_q.accepted, res_q.ready_res};

endmodule
`default_nettype wire

[src/otfr_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otfr_step
// Next-state and result logic for one beat: arming, edge timing, bit sampling,
// poll outcome with timeout, parity and message type check.
// ----------------------------------------------------------------------------
module otfr_step (
  input  otfr_pkg::cfg_t      cfg_i,
  input  otfr_pkg::item_t     item_i,
  input  otfr_pkg::rx_state_t cur_i,
  output otfr_pkg::rx_state_t nxt_o,
  output otfr_pkg::result_t   res_o
);

  otfr_pkg::time_t  now;
  otfr_pkg::time_t  elapsed;
  otfr_pkg::time_t  win;
  otfr_pkg::time_t  tmo;
  otfr_pkg::phase_e ph;
  logic [2:0]       frame_kind;
  logic             frame_ok;
  logic             acc;
  logic             done;

  assign now        = otfr_pkg::time_t'(item_i.time_us);
  assign elapsed    = now - cur_i.mark;
  assign win        = otfr_pkg::time_t'(cfg_i.bit_window);
  assign tmo        = otfr_pkg::time_t'(cfg_i.timeout);
  assign frame_kind = cur_i.frame[otfr_pkg::TYPE_LSB +: 3];
  assign frame_ok   = !(^cur_i.frame) &&
                      (cfg_i.slave_mode ? (frame_kind <= 3'd2) : frame_kind[2]);

  always_comb begin
    nxt_o = cur_i;
    acc   = 1'b0;
    done  = 1'b0;
    ph    = cur_i.phase;
    case (otfr_pkg::cmd_e'(item_i.cmd))
      otfr_pkg::CMD_EDGE: begin
        // a slave treats a high edge while idle as the start edge
        if (ph == otfr_pkg::PH_READY && cfg_i.slave_mode && item_i.level) begin
          ph = otfr_pkg::PH_WAIT;
        end
        case (ph)
          otfr_pkg::PH_WAIT: begin
            nxt_o.phase = item_i.level ? otfr_pkg::PH_START : otfr_pkg::PH_BAD;
            nxt_o.mark  = now;
          end
          otfr_pkg::PH_START: begin
            if (elapsed < win && !item_i.level) begin
              nxt_o.phase = otfr_pkg::PH_RECV;
              nxt_o.mark  = now;
              nxt_o.cnt   = '0;
              nxt_o.frame = '0;
            end else if (elapsed >= win) begin
              nxt_o.phase = otfr_pkg::PH_BAD;
              nxt_o.mark  = now;
            end
          end
          otfr_pkg::PH_RECV: begin
            if (elapsed > win) begin
              if (cur_i.cnt < otfr_pkg::cnt_t'(otfr_pkg::FRAME_BITS)) begin
                nxt_o.frame = {cur_i.frame[otfr_pkg::FRAME_BITS-2:0], ~item_i.level};
                nxt_o.cnt   = cur_i.cnt + 1'b1;
              end else begin
                nxt_o.phase = otfr_pkg::PH_DONE;
              end
              nxt_o.mark = now;
            end
          end
          default: begin
          end
        endcase
      end
      otfr_pkg::CMD_POLL: begin
        if (cur_i.phase != otfr_pkg::PH_READY) begin
          if (elapsed > tmo) begin
            nxt_o.phase  = otfr_pkg::PH_READY;
            nxt_o.status = otfr_pkg::ST_TIMEOUT;
            done         = 1'b1;
          end else if (cur_i.phase == otfr_pkg::PH_BAD) begin
            nxt_o.phase  = otfr_pkg::PH_READY;
            nxt_o.status = otfr_pkg::ST_BAD;
            done         = 1'b1;
          end else if (cur_i.phase == otfr_pkg::PH_DONE) begin
            nxt_o.phase  = otfr_pkg::PH_READY;
            nxt_o.status = frame_ok ? otfr_pkg::ST_OK : otfr_pkg::ST_BAD;
            done         = 1'b1;
          end
        end
      end
      otfr_pkg::CMD_ARM: begin
        if (cur_i.phase == otfr_pkg::PH_READY) begin
          nxt_o.phase  = otfr_pkg::PH_WAIT;
          nxt_o.frame  = '0;
          nxt_o.status = otfr_pkg::ST_NONE;
          nxt_o.mark   = now;
          acc          = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.ready_res = (nxt_o.phase == otfr_pkg::PH_READY);
    res_o.accepted  = acc;
    res_o.done_res  = done;
    res_o.frame     = 32'(nxt_o.frame);
    res_o.status    = nxt_o.status;
  end

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the edge-timed frame receiver.
// Events (line edges, polls, arms) go in as stream beats with bursty gaps,
// and a shadow copy of the receiver works out each result beat. Result beats
// are compared field by field as they come out under a varying stall pattern
// that includes long hold-offs. Directed corner cases come first, then
// randomised frames and noise over a range of role, window and timeout
// settings.
// ----------------------------------------------------------------------------
module tb;
  import otfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  class frame_rx_shadow;
    logic        slave;
    logic [15:0] window;
    logic [23:0] tmo;
    phase_e      ph;
    frame_t      shreg;
    int unsigned nbits;
    time_t       mark;
    status_e     st;
    result_t     pending_reports[$];
    int          errors;

    function new();
      slave  = 1'b0;
      window = BIT_WINDOW_RST;
      tmo    = TIMEOUT_RST;
      ph     = PH_READY;
      shreg  = '0;
      nbits  = 0;
      mark   = '0;
      st     = ST_NONE;
      errors = 0;
    endfunction

    function void note_event(logic [1:0] cmd, time_t now, logic lvl);
      time_t      el;
      logic       acc;
      logic       done;
      logic [2:0] typ;
      logic       ok;
      result_t    r;
      el   = now - mark;
      acc  = 1'b0;
      done = 1'b0;
      case (cmd)
        CMD_EDGE: begin
          if (ph == PH_READY && slave && lvl) ph = PH_WAIT;
          if (ph == PH_WAIT) begin
            ph   = lvl ? PH_START : PH_BAD;
            mark = now;
          end else if (ph == PH_START) begin
            if (el < window && !lvl) begin
              ph    = PH_RECV;
              mark  = now;
              nbits = 0;
              shreg = '0;
            end else if (el >= window) begin
              ph   = PH_BAD;
              mark = now;
            end
          end else if (ph == PH_RECV) begin
            if (el > window) begin
              if (nbits < FRAME_BITS) begin
                shreg = {shreg[FRAME_BITS-2:0], ~lvl};
                nbits++;
              end else begin
                ph = PH_DONE;
              end
              mark = now;
            end
          end
        end
        CMD_POLL: begin
          if (ph != PH_READY) begin
            if (el > tmo) begin
              ph   = PH_READY;
              st   = ST_TIMEOUT;
              done = 1'b1;
            end else if (ph == PH_BAD) begin
              ph   = PH_READY;
              st   = ST_BAD;
              done = 1'b1;
            end else if (ph == PH_DONE) begin
              typ  = shreg[TYPE_LSB +: 3];
              ok   = (^shreg == 1'b0) && (slave ? (typ <= 3'd2) : (typ >= 3'd4));
              ph   = PH_READY;
              st   = ok ? ST_OK : ST_BAD;
              done = 1'b1;
            end
          end
        end
        CMD_ARM: begin
          if (ph == PH_READY) begin
            ph    = PH_WAIT;
            shreg = '0;
            st    = ST_NONE;
            mark  = now;
            acc   = 1'b1;
          end
        end
        default: ;
      endcase
      r.ready_res = (ph == PH_READY);
      r.accepted  = acc;
      r.done_res  = done;
      r.frame     = shreg;
      r.status    = st;
      pending_reports.push_back(r);
    endfunction

    function void check_report(logic [39:0] beat);
      result_t exp;
      if (pending_reports.size() == 0) begin
        $error("result beat with nothing expected: %h", beat);
        errors++;
        return;
      end
      exp = pending_reports.pop_front();
      if (beat[0] !== exp.ready_res) begin
        $error("ready_res: expected %0d, got %0d", exp.ready_res, beat[0]);
        errors++;
      end
      if (beat[1] !== exp.accepted) begin
        $error("accepted: expected %0d, got %0d", exp.accepted, beat[1]);
        errors++;
      end
      if (beat[2] !== exp.done_res) begin
        $error("done_res: expected %0d, got %0d", exp.done_res, beat[2]);
        errors++;
      end
      if (beat[34:3] !== exp.frame) begin
        $error("frame: expected %h, got %h", exp.frame, beat[34:3]);
        errors++;
      end
      if (beat[36:35] !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, beat[36:35]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_idx_i       = CFG_SLAVE_MODE;
  logic [23:0] cfg_data_i      = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = CMD_EDGE;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  frame_rx_shadow shadow;
  time_t          now_us;
  int             burst_left = 0;
  int unsigned    sent_items = 0;
  int unsigned    cycles     = 0;
  logic [31:0]    rx_cyc     = '0;
  int             hold_left  = 0;

  opentherm_frame_receiver uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: free-running, then random, then a fixed pattern, then a hold and mostly-ready random
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) shadow.check_report(m_axis_tdata_o);
    rx_cyc = rx_cyc + 1;
    case (rx_cyc[8:7])
      2'd0: m_axis_tready_i <= 1'b1;
      2'd1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      2'd2: m_axis_tready_i <= (rx_cyc % 3) != 0;
      default: begin
        if (rx_cyc[6:0] == 7'd0) hold_left = 100;
        if (hold_left > 0) begin
          hold_left = hold_left - 1;
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= $urandom_range(0, 4) != 0;
        end
      end
    endcase
  end

  task automatic send_event(input logic [1:0] cmd, input time_t at, input logic lvl);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {7'd0, lvl, at};
    do @(posedge clk_i); while (!s_axis_tready_o);
    shadow.note_event(cmd, at, lvl);
    sent_items++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (shadow.pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setup(input logic sl, input logic [15:0] win, input logic [23:0] tmo);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SLAVE_MODE;
    cfg_data_i <= {23'd0, sl};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BIT_WINDOW;
    cfg_data_i <= {8'd0, win};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TIMEOUT;
    cfg_data_i <= tmo;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow.slave  = sl;
    shadow.window = win;
    shadow.tmo    = tmo;
  endtask

  task automatic run_frame();
    frame_t     payload;
    logic [2:0] kind;
    time_t      m;
    logic       lvl;
    int         i;
    // finish off anything left over so the frame starts from ready
    if (shadow.ph != PH_READY) begin
      now_us = shadow.mark + time_t'(shadow.tmo) + 32'd1 + $urandom_range(0, 40);
      send_event(CMD_POLL, now_us, 1'b0);
    end
    payload = $urandom();
    if ($urandom_range(0, 3) != 0) begin
      kind = shadow.slave ? 3'($urandom_range(0, 2)) : 3'($urandom_range(4, 7));
      payload[TYPE_LSB +: 3] = kind;
      payload[0] = payload[0] ^ (^payload);
    end
    now_us += $urandom_range(1, 5000);
    if (!shadow.slave) begin
      send_event(CMD_ARM, now_us, 1'($urandom_range(0, 1)));
      now_us += $urandom_range(0, 3000);
    end
    if ($urandom_range(0, 15) == 0) begin
      send_event(CMD_EDGE, now_us, 1'b0);
      return;
    end
    send_event(CMD_EDGE, now_us, 1'b1);
    m = now_us;
    if ($urandom_range(0, 15) == 0 || shadow.window == 16'd0)
      now_us = m + shadow.window + $urandom_range(0, 100);
    else
      now_us = m + $urandom_range(0, shadow.window - 1);
    send_event(CMD_EDGE, now_us, 1'b0);
    if (shadow.ph == PH_RECV) begin
      for (i = 0; i <= FRAME_BITS; i++) begin
        m = now_us;
        // mid-bit transition, inside the window
        if ($urandom_range(0, 3) == 0) begin
          now_us = m + $urandom_range(0, shadow.window);
          send_event(CMD_EDGE, now_us, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 60) == 0)
          send_event(CMD_POLL, now_us + $urandom_range(0, 2000), 1'b0);
        now_us = m + shadow.window + 32'd1 + (($urandom_range(0, 7) == 0) ?
                 $urandom_range(0, shadow.window) : $urandom_range(0, 3));
        if (i == FRAME_BITS && $urandom_range(0, 15) == 0) break;
        lvl = (i < FRAME_BITS) ? ~payload[FRAME_BITS-1-i] : 1'($urandom_range(0, 1));
        send_event(CMD_EDGE, now_us, lvl);
      end
    end
    now_us += $urandom_range(0, 40);
    send_event(CMD_POLL, now_us, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_noise();
    int n;
    int k;
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) now_us = $urandom();
      else now_us += $urandom_range(0, 2 * shadow.window + 10);
      send_event(2'($urandom_range(0, 3)), now_us, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int          p;
    int unsigned phase_start;
    logic        sl;
    logic [15:0] win;
    logic [23:0] tmo;
    shadow = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed corner cases at the reset settings (master, 750 us, 1 s)
    send_event(CMD_POLL,   32'd0,          1'b0);  // poll while ready
    send_event(CMD_UNUSED, 32'hFFFF_FFFF,  1'b1);
    send_event(CMD_EDGE,   32'd10,         1'b1);  // master ignores edges when ready
    send_event(CMD_EDGE,   32'd11,         1'b0);
    send_event(CMD_ARM,    32'd100,        1'b0);
    send_event(CMD_ARM,    32'd110,        1'b1);  // busy, not taken
    send_event(CMD_POLL,   32'd200,        1'b0);  // nothing yet
    send_event(CMD_EDGE,   32'd300,        1'b0);  // low while waiting
    send_event(CMD_EDGE,   32'd301,        1'b1);  // ignored once invalid
    send_event(CMD_POLL,   32'd400,        1'b0);
    send_event(CMD_ARM,    32'd1000,       1'b0);
    send_event(CMD_EDGE,   32'd1200,       1'b1);
    send_event(CMD_EDGE,   32'd1300,       1'b1);  // high inside start window
    send_event(CMD_EDGE,   32'd1950,       1'b1);  // exactly at the window
    send_event(CMD_POLL,   32'd2000,       1'b1);
    send_event(CMD_ARM,    32'hFFFF_FF00,  1'b0);
    send_event(CMD_EDGE,   32'hFFFF_FFFF,  1'b1);
    send_event(CMD_EDGE,   32'h0000_0100,  1'b0);  // across the wrap
    send_event(CMD_EDGE,   32'h0000_03EE,  1'b1);  // exactly one window on
    send_event(CMD_EDGE,   32'h0000_03EF,  1'b0);
    send_event(CMD_POLL,   32'h000F_4630,  1'b0);  // timeout while receiving
    send_event(CMD_ARM,    32'd2000000,    1'b0);
    send_event(CMD_EDGE,   32'd2000010,    1'b0);
    send_event(CMD_POLL,   32'd3100000,    1'b0);  // timeout beats invalid

    for (p = 0; p < 12; p++) begin
      case (p)
        0:       begin sl = 1'b0; win = 16'd750;   tmo = 24'd1000000; end
        1:       begin sl = 1'b1; win = 16'd750;   tmo = 24'd1000000; end
        2:       begin sl = 1'b0; win = 16'd0;     tmo = 24'hFFFFFF;  end
        3:       begin sl = 1'b1; win = 16'hFFFF;  tmo = 24'hFFFFFF;  end
        4:       begin sl = 1'b0; win = 16'hFFFF;  tmo = 24'd5000;    end
        5:       begin sl = 1'b1; win = 16'd1;     tmo = 24'd0;       end
        6:       begin sl = 1'b0; win = 16'd1;     tmo = 24'd100;     end
        7:       begin sl = 1'b1; win = 16'd0;     tmo = 24'd50;      end
        default: begin
          sl  = 1'($urandom_range(0, 1));
          win = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(2, 2000));
          tmo = 24'($urandom_range(200000, 24'hFFFFFF));
        end
      endcase
      apply_setup(sl, win, tmo);
      if (p % 3 == 2) now_us = $urandom();
      phase_start = sent_items;
      while (sent_items - phase_start < 30) begin
        if ($urandom_range(0, 5) == 0) run_noise();
        else run_frame();
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (shadow.pending_reports.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    if (shadow.errors == 0 && shadow.pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[opentherm_frame_receiver.f]
src/otfr_pkg.sv
src/otfr_step.sv
src/opentherm_frame_receiver.sv
bench/tb.sv
